/* hdl/cbf_pkg.sv */
// Shared constants, types and helper functions for the cubic Bezier flattener.
package cbf_pkg;

    localparam int COORD_W     = 16;
    localparam int CNT_W       = 7;
    localparam int MAX_SEG     = 64;
    localparam int SQ_W        = 2 * CNT_W;
    localparam int W_W         = 19;
    localparam int DEN_W       = 19;
    localparam int PROD_W      = W_W + 1 + COORD_W;
    localparam int NUM_W       = PROD_W;
    localparam int MAG_W       = 34;
    localparam int Q_W         = 16;
    localparam int DIV_STAGES  = 8;
    localparam int BITS_PER_ST = Q_W / DIV_STAGES;
    localparam int THICK_W     = 16;
    localparam int COLOR_W     = 24;
    localparam int DIV_FIRST   = 6;
    localparam int LAST_ST     = DIV_FIRST + DIV_STAGES - 1;

    localparam logic [CNT_W-1:0] SEG_RESET = CNT_W'(22);

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        logic               valid;
        logic               zero;
        logic               last;
        logic [THICK_W-1:0] thick;
        logic [COLOR_W-1:0] color;
    } meta_t;

    typedef struct packed {
        logic [MAG_W-1:0] rem;
        logic [Q_W-1:0]   quo;
    } div_t;

    function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] r;
        if (c == '0)
            r = CNT_W'(1);
        else if (c > CNT_W'(MAX_SEG))
            r = CNT_W'(MAX_SEG);
        else
            r = c;
        return r;
    endfunction

    function automatic div_t div_step(input div_t d, input logic [DEN_W-1:0] den,
                                      input int b);
        logic [MAG_W-1:0] sub;
        div_t             r;
        sub = MAG_W'(den) << b;
        r = d;
        if (d.rem >= sub) begin
            r.rem    = d.rem - sub;
            r.quo[b] = 1'b1;
        end
        return r;
    endfunction

endpackage

/* hdl/cubic_bezier_flattener.sv */
// Cubic Bezier flattener: splits one curve into line segments through a deep pipeline.
// A curve is taken when the sequencer is idle; it then issues the start point and then
// N curve points, one point per cycle while the output is not stalled.
// Segments follow one per cycle, unless the output stalls, through six arithmetic stages
// and an eight-stage radix-4 divider.
// Reset clears the sequencer, all valid bits and sets the segment count to 22.
module cubic_bezier_flattener (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [cbf_pkg::CNT_W-1:0]   cfg_wdata,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  cbf_pkg::coord_t             start_x,
    input  cbf_pkg::coord_t             start_y,
    input  cbf_pkg::coord_t             ctrl1_x,
    input  cbf_pkg::coord_t             ctrl1_y,
    input  cbf_pkg::coord_t             ctrl2_x,
    input  cbf_pkg::coord_t             ctrl2_y,
    input  cbf_pkg::coord_t             end_x,
    input  cbf_pkg::coord_t             end_y,
    input  logic [cbf_pkg::THICK_W-1:0] thickness,
    input  logic [cbf_pkg::COLOR_W-1:0] color,
    output logic                        out_valid,
    input  logic                        out_ready,
    output cbf_pkg::coord_t             seg_start_x,
    output cbf_pkg::coord_t             seg_start_y,
    output cbf_pkg::coord_t             seg_end_x,
    output cbf_pkg::coord_t             seg_end_y,
    output logic [cbf_pkg::THICK_W-1:0] out_thickness,
    output logic [cbf_pkg::COLOR_W-1:0] out_color,
    output logic                        last_segment
);
    import cbf_pkg::*;

    logic [CNT_W-1:0]   seg_count_reg;
    logic               busy_reg;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   n_reg;
    coord_t             cur_px_reg [4];
    coord_t             cur_py_reg [4];
    logic [THICK_W-1:0] cur_thick_reg;
    logic [COLOR_W-1:0] cur_color_reg;

    logic               advance;
    logic               in_acc;

    meta_t              meta_reg [0:LAST_ST];
    meta_t              meta_next;

    logic [CNT_W-1:0]   s0_i_reg, s0_u_reg, s0_n_reg;
    coord_t             s0_px_reg [4], s0_py_reg [4];
    logic [CNT_W-1:0]   s1_i_reg, s1_u_reg, s1_n_reg;
    logic [SQ_W-1:0]    s1_i2_reg, s1_u2_reg, s1_n2_reg;
    coord_t             s1_px_reg [4], s1_py_reg [4];
    logic [W_W-1:0]     s2_w_reg [4];
    logic [DEN_W-1:0]   s2_den_reg;
    coord_t             s2_px_reg [4], s2_py_reg [4];
    logic signed [PROD_W-1:0] s3_prx_reg [4], s3_pry_reg [4];
    logic [DEN_W-1:0]   s3_den_reg;
    logic signed [NUM_W-1:0]  s4_sx_reg, s4_sy_reg;
    logic [DEN_W-1:0]   s4_den_reg;
    logic [NUM_W-1:0]   negx_tmp, negy_tmp;

    div_t               dv_reg   [2][DIV_FIRST-1:LAST_ST];
    logic               neg_reg  [2][DIV_FIRST-1:LAST_ST];
    logic [DEN_W-1:0]   dden_reg [DIV_FIRST-1:LAST_ST];
    div_t               dv_next  [2][DIV_FIRST:LAST_ST];

    logic [Q_W:0]       qx_s, qy_s;
    coord_t             qx, qy;
    coord_t             prev_x_reg, prev_y_reg;
    logic               out_valid_reg;
    coord_t             seg_start_x_reg, seg_start_y_reg, seg_end_x_reg, seg_end_y_reg;
    logic [THICK_W-1:0] out_thick_reg;
    logic [COLOR_W-1:0] out_color_reg;
    logic               last_reg;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !busy_reg;
    assign in_acc   = in_valid && in_ready;
    assign idx_next = idx_reg + CNT_W'(1);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            seg_count_reg <= SEG_RESET;
        else if (cfg_we)
            seg_count_reg <= cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (in_acc) begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (busy_reg && advance) begin
            if (idx_reg == n_reg)
                busy_reg <= 1'b0;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk) begin
        if (in_acc) begin
            n_reg         <= clamp_count(seg_count_reg);
            cur_px_reg[0] <= start_x;
            cur_py_reg[0] <= start_y;
            cur_px_reg[1] <= ctrl1_x;
            cur_py_reg[1] <= ctrl1_y;
            cur_px_reg[2] <= ctrl2_x;
            cur_py_reg[2] <= ctrl2_y;
            cur_px_reg[3] <= end_x;
            cur_py_reg[3] <= end_y;
            cur_thick_reg <= thickness;
            cur_color_reg <= color;
        end
    end

    always_comb begin
        meta_next.valid = busy_reg;
        meta_next.zero  = (idx_reg == '0);
        meta_next.last  = (idx_reg == n_reg);
        meta_next.thick = cur_thick_reg;
        meta_next.color = cur_color_reg;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int j = 0; j <= LAST_ST; j++)
                meta_reg[j] <= '0;
        end
        else if (advance) begin
            meta_reg[0] <= meta_next;
            for (int j = 1; j <= LAST_ST; j++)
                meta_reg[j] <= meta_reg[j-1];
        end
    end

    always_comb begin
        negx_tmp = -s4_sx_reg;
        negy_tmp = -s4_sy_reg;
        for (int a = 0; a < 2; a++)
            for (int k = DIV_FIRST; k <= LAST_ST; k++)
                dv_next[a][k] = div_step(
                    div_step(dv_reg[a][k-1], dden_reg[k-1],
                             Q_W - 1 - (k - DIV_FIRST) * BITS_PER_ST),
                    dden_reg[k-1], Q_W - 2 - (k - DIV_FIRST) * BITS_PER_ST);
    end

    always_ff @(posedge clk) begin
        if (advance) begin
            s0_i_reg <= idx_reg;
            s0_u_reg <= n_reg - idx_reg;
            s0_n_reg <= n_reg;
            s0_px_reg <= cur_px_reg;
            s0_py_reg <= cur_py_reg;

            s1_i_reg  <= s0_i_reg;
            s1_u_reg  <= s0_u_reg;
            s1_n_reg  <= s0_n_reg;
            s1_i2_reg <= s0_i_reg * s0_i_reg;
            s1_u2_reg <= s0_u_reg * s0_u_reg;
            s1_n2_reg <= s0_n_reg * s0_n_reg;
            s1_px_reg <= s0_px_reg;
            s1_py_reg <= s0_py_reg;

            s2_w_reg[0] <= W_W'(s1_u2_reg) * W_W'(s1_u_reg);
            s2_w_reg[1] <= W_W'(3 * W_W'(s1_u2_reg) * W_W'(s1_i_reg));
            s2_w_reg[2] <= W_W'(3 * W_W'(s1_i2_reg) * W_W'(s1_u_reg));
            s2_w_reg[3] <= W_W'(s1_i2_reg) * W_W'(s1_i_reg);
            s2_den_reg  <= DEN_W'(s1_n2_reg) * DEN_W'(s1_n_reg);
            s2_px_reg   <= s1_px_reg;
            s2_py_reg   <= s1_py_reg;

            for (int k = 0; k < 4; k++) begin
                s3_prx_reg[k] <= $signed({1'b0, s2_w_reg[k]}) * s2_px_reg[k];
                s3_pry_reg[k] <= $signed({1'b0, s2_w_reg[k]}) * s2_py_reg[k];
            end
            s3_den_reg <= s2_den_reg;

            s4_sx_reg  <= s3_prx_reg[0] + s3_prx_reg[1] + s3_prx_reg[2] + s3_prx_reg[3];
            s4_sy_reg  <= s3_pry_reg[0] + s3_pry_reg[1] + s3_pry_reg[2] + s3_pry_reg[3];
            s4_den_reg <= s3_den_reg;

            neg_reg[0][DIV_FIRST-1]    <= s4_sx_reg[NUM_W-1];
            neg_reg[1][DIV_FIRST-1]    <= s4_sy_reg[NUM_W-1];
            dv_reg[0][DIV_FIRST-1].rem <= s4_sx_reg[NUM_W-1] ? negx_tmp[MAG_W-1:0]
                                                              : s4_sx_reg[MAG_W-1:0];
            dv_reg[1][DIV_FIRST-1].rem <= s4_sy_reg[NUM_W-1] ? negy_tmp[MAG_W-1:0]
                                                              : s4_sy_reg[MAG_W-1:0];
            dv_reg[0][DIV_FIRST-1].quo <= '0;
            dv_reg[1][DIV_FIRST-1].quo <= '0;
            dden_reg[DIV_FIRST-1]      <= s4_den_reg;

            for (int k = DIV_FIRST; k <= LAST_ST; k++) begin
                dden_reg[k] <= dden_reg[k-1];
                for (int a = 0; a < 2; a++) begin
                    dv_reg[a][k]  <= dv_next[a][k];
                    neg_reg[a][k] <= neg_reg[a][k-1];
                end
            end
        end
    end

    assign qx_s = neg_reg[0][LAST_ST] ? -{1'b0, dv_reg[0][LAST_ST].quo}
                                      :  {1'b0, dv_reg[0][LAST_ST].quo};
    assign qy_s = neg_reg[1][LAST_ST] ? -{1'b0, dv_reg[1][LAST_ST].quo}
                                      :  {1'b0, dv_reg[1][LAST_ST].quo};
    assign qx = qx_s[COORD_W-1:0];
    assign qy = qy_s[COORD_W-1:0];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= meta_reg[LAST_ST].valid && !meta_reg[LAST_ST].zero;
    end

    always_ff @(posedge clk) begin
        if (advance && meta_reg[LAST_ST].valid) begin
            prev_x_reg      <= qx;
            prev_y_reg      <= qy;
            seg_start_x_reg <= prev_x_reg;
            seg_start_y_reg <= prev_y_reg;
            seg_end_x_reg   <= qx;
            seg_end_y_reg   <= qy;
            out_thick_reg   <= meta_reg[LAST_ST].thick;
            out_color_reg   <= meta_reg[LAST_ST].color;
            last_reg        <= meta_reg[LAST_ST].last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign seg_start_x   = seg_start_x_reg;
    assign seg_start_y   = seg_start_y_reg;
    assign seg_end_x     = seg_end_x_reg;
    assign seg_end_y     = seg_end_y_reg;
    assign out_thickness = out_thick_reg;
    assign out_color     = out_color_reg;
    assign last_segment  = last_reg;

    // The sequencer never runs past the segment count of the curve it holds.
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (idx_reg <= n_reg))
        else $error("segment index beyond segment count");

    // The start-point entry carries the full weight on the start point.
    a_zero_weight: assert property (@(posedge clk) disable iff (!rst_n)
        (meta_reg[0].valid && meta_reg[0].zero) |-> (s0_u_reg == s0_n_reg))
        else $error("start-point entry has wrong weight");

    // A stalled output freezes the pipeline.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(meta_reg[LAST_ST]))
        else $error("pipeline moved during a stall");

    // Quotient magnitude stays within the coordinate range.
    a_quo_range: assert property (@(posedge clk) disable iff (!rst_n)
        meta_reg[LAST_ST].valid |->
            (dv_reg[0][LAST_ST].quo <= Q_W'(32768) && dv_reg[1][LAST_ST].quo <= Q_W'(32768)))
        else $error("quotient out of range");

endmodule
